>>> src/wchht_pkg.sv
// Shared constants and field widths for the windowed channel hit trigger.
package wchht_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_SPAN = 2'd0;
  localparam logic [1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_HOLDOFF     = 2'd2;

  // Input operation codes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_HIT    = 1'b1;

  // Field widths
  localparam int unsigned DET_W    = 24;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned CHAN_W   = 16;
  localparam int unsigned THR_W    = 13;
  localparam int unsigned SRC_W    = 16;
  localparam int unsigned CNT_OUT_W = 13;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 80;

  // Width of the window epoch stamped into each hit map entry; zero means clear
  localparam int unsigned EPOCH_W = 16;

endpackage

>>> src/windowed_channel_hit_trigger_top.sv
// Top level of the windowed channel hit trigger with its epoch-stamped hit map.
//
//  Channel   Direction  Payload                                         Handshake
//  s_axis    in         tdata: detector_id, start_time, channel          tvalid/tready
//                       tuser: operation
//  m_axis    out        tdata: trigger_time, channels_hit, zero pad      tvalid/tready
//  cfg       in         cfg_index_i, cfg_data_i                          cfg_valid_i/cfg_ready_o
//
// A mapped hit reads the hit map in the accept cycle and does the compare and
// write-back in the next. A header that does not close the window is handled in
// its accept cycle; a closing header goes through multiply, compare and update,
// waiting before the update while the output register has not drained. After
// reset, and after every 65535 closed windows when the epoch wraps, the hit map
// is swept clear with the input held off. Configuration is always ready.
module windowed_channel_hit_trigger_top
  import wchht_pkg::*;
#(
  parameter int unsigned MAPPED_CHANNELS = 5120,
  parameter int unsigned CHANNEL_BASE    = 2560,
  parameter int unsigned SKIPPED_FIBER   = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [23:0] detector_id, [87:24] start_time, [103:88] channel
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic [0:0]            s_axis_tuser,
  // trigger stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [63:0] trigger_time, [76:64] channels_hit, [79:77] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int unsigned IW = (MAPPED_CHANNELS > 1) ? $clog2(MAPPED_CHANNELS) : 1;
  localparam int unsigned DW = $clog2(MAPPED_CHANNELS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAPPED_CHANNELS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HIT  = 3'd1;
  localparam logic [2:0] ST_HDR  = 3'd2;
  localparam logic [2:0] ST_FIRE = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  // Configuration
  logic [31:0]      span_q, holdoff_q;
  logic [THR_W-1:0] thr_q;

  // Control and window state
  logic [2:0]         state_q, state_d;
  logic [IW-1:0]      clr_cnt_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [TIME_W-1:0]  window_start_q, last_emit_q, hdr_time_q;
  logic [DW-1:0]      distinct_q;
  logic [SRC_W-1:0]   sources_q, max_q;
  logic               skipping_q;
  logic [IW-1:0]      idx_q;
  logic [THR_W+SRC_W-1:0] need_q;
  logic               hold_ok_q;

  // Hit map
  logic [EPOCH_W-1:0] map_mem [MAPPED_CHANNELS];
  logic [EPOCH_W-1:0] rd_q;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata;

  // Output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Input field decode
  logic               in_op;
  logic [DET_W-1:0]   in_det;
  logic [TIME_W-1:0]  in_time;
  logic [CHAN_W-1:0]  in_chan;
  logic               in_accept;
  logic               hdr_skip, hdr_closes;
  logic [CHAN_W+1:0]  chan_rel;
  logic               chan_mapped;
  logic [TIME_W:0]    window_end;
  logic [SRC_W-1:0]   max_new;
  logic [31:0]        distinct_ext;
  logic               fire, out_free, close_go, hit_new;

  assign in_op   = s_axis_tuser[0];
  assign in_det  = s_axis_tdata[23:0];
  assign in_time = s_axis_tdata[87:24];
  assign in_chan = s_axis_tdata[103:88];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Window end is formed one bit wider so that it never wraps
  assign window_end = {1'b0, window_start_q} + {{(TIME_W-31){1'b0}}, span_q};
  assign hdr_skip   = (in_det[23:16] == 8'(SKIPPED_FIBER));
  assign hdr_closes = ({1'b0, in_time} >= window_end);

  // Map the channel; a negative offset shows in the top bit
  assign chan_rel    = {2'b00, in_chan} - (CHAN_W+2)'(CHANNEL_BASE);
  assign chan_mapped = !chan_rel[CHAN_W+1] && (chan_rel < (CHAN_W+2)'(MAPPED_CHANNELS));

  assign max_new      = (sources_q > max_q) ? sources_q : max_q;
  assign distinct_ext = 32'(distinct_q);
  assign fire         = (distinct_ext >= {3'b000, need_q}) && hold_ok_q;
  assign out_free     = !out_valid_q || m_axis_tready;
  assign close_go     = (state_q == ST_FIRE) && (!fire || out_free);
  assign hit_new      = (rd_q != epoch_q);

  // Hit map write: stamp the current epoch, or zero during a sweep
  assign mem_we    = ((state_q == ST_HIT) && hit_new) || (state_q == ST_CLR);
  assign mem_waddr = (state_q == ST_CLR) ? clr_cnt_q : idx_q;
  assign mem_wdata = (state_q == ST_CLR) ? '0 : epoch_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept && (in_op == OP_HIT)) begin
      rd_q <= map_mem[chan_rel[IW-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_op == OP_HIT) begin
            if (!skipping_q && chan_mapped) begin
              state_d = ST_HIT;
            end
          end else if (!hdr_skip && hdr_closes) begin
            state_d = ST_HDR;
          end
        end
      end
      ST_HIT:  state_d = ST_IDLE;
      ST_HDR:  state_d = ST_FIRE;
      ST_FIRE: begin
        if (close_go) begin
          state_d = (epoch_q == '1) ? ST_CLR : ST_IDLE;
        end
      end
      ST_CLR: begin
        if (clr_cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLR;
      clr_cnt_q      <= '0;
      epoch_q        <= EPOCH_W'(1);
      window_start_q <= '0;
      last_emit_q    <= '0;
      distinct_q     <= '0;
      sources_q      <= '0;
      max_q          <= '0;
      skipping_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      span_q         <= '0;
      thr_q          <= '0;
      holdoff_q      <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WINDOW_SPAN: span_q    <= cfg_data_i;
          REG_THRESHOLD:   thr_q     <= cfg_data_i[THR_W-1:0];
          REG_HOLDOFF:     holdoff_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Load a new trigger ahead of dropping the one just taken
      if (close_go && fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          // Unskipped headers that do not close the window count as a source right away
          if (in_accept && (in_op == OP_HEADER)) begin
            skipping_q <= hdr_skip;
            if (!hdr_skip && !hdr_closes && (sources_q != '1)) begin
              sources_q <= sources_q + SRC_W'(1);
            end
          end
        end
        ST_HIT: begin
          if (hit_new) begin
            distinct_q <= distinct_q + DW'(1);
          end
        end
        ST_HDR: begin
          max_q <= max_new;
        end
        ST_FIRE: begin
          if (close_go) begin
            if (fire) begin
              last_emit_q <= window_start_q;
            end
            window_start_q <= hdr_time_q;
            distinct_q     <= '0;
            sources_q      <= SRC_W'(1);
            // Advance the epoch; on wrap, sweep the map and restart at one
            epoch_q        <= (epoch_q == '1) ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
          end
        end
        ST_CLR: begin
          clr_cnt_q <= (clr_cnt_q == LAST_IDX) ? '0 : clr_cnt_q + IW'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hdr_time_q <= in_time;
      idx_q      <= chan_rel[IW-1:0];
    end
    if (state_q == ST_HDR) begin
      need_q    <= thr_q * max_new;
      hold_ok_q <= ({1'b0, window_start_q} >=
                    ({1'b0, last_emit_q} + {{(TIME_W-31){1'b0}}, holdoff_q}));
    end
    if (close_go && fire) begin
      out_data_q <= {3'b000, distinct_ext[CNT_OUT_W-1:0], window_start_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  // The map is never written with the reserved clear epoch outside a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != ST_CLR)) |-> (mem_wdata != '0))
    else $error("hit map stamped with the clear epoch");

  // Distinct count cannot exceed the number of mapped channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    distinct_ext <= 32'(MAPPED_CHANNELS))
    else $error("distinct hit count overflow");

  // A firing window always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (close_go && fire) |=> (m_axis_tvalid && (m_axis_tdata[63:0] == $past(window_start_q))))
    else $error("trigger lost");

  // A closed window restarts with a single source and an empty hit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_go |=> ((sources_q == SRC_W'(1)) && (distinct_q == '0)))
    else $error("window not restarted");

  // No item is taken during a sweep of the hit map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("input accepted during hit map sweep");
`endif

endmodule
